>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every rising clock edge outside reset.
`define KSI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define KSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`else

`define KSI_ASSERT(lbl, clk, rst_n, prop, msg)
`define KSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hw/rtl/ksi_pkg.sv
package ksi_pkg;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] BREAK_PREFIX = 8'hF0;
  localparam logic [7:0] EXT_PREFIX   = 8'hE0;
  localparam logic [7:0] SHIFT_CODE   = 8'h12;
  localparam logic [7:0] SET1_BREAK   = 8'h80;
  localparam logic [7:0] PRINT_LIMIT  = 8'h7F;
  localparam logic [23:0] SPECIAL_PAGE = 24'h0000FF;

  // decoded work item handed from front to back
  typedef struct packed {
    logic            is_read;
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;   // bytes[0] goes out first
  } cmd_t;

  // 8042 translation, lower half (upper half is nearly identity)
  localparam logic [7:0] SET1_LO [128] = '{
    8'hff, 8'h43, 8'h41, 8'h3f, 8'h3d, 8'h3b, 8'h3c, 8'h58,
    8'h64, 8'h44, 8'h42, 8'h40, 8'h3e, 8'h0f, 8'h29, 8'h59,
    8'h65, 8'h38, 8'h2a, 8'h70, 8'h1d, 8'h10, 8'h02, 8'h5a,
    8'h66, 8'h71, 8'h2c, 8'h1f, 8'h1e, 8'h11, 8'h03, 8'h5b,
    8'h67, 8'h2e, 8'h2d, 8'h20, 8'h12, 8'h05, 8'h04, 8'h5c,
    8'h68, 8'h39, 8'h2f, 8'h21, 8'h14, 8'h13, 8'h06, 8'h5d,
    8'h69, 8'h31, 8'h30, 8'h23, 8'h22, 8'h15, 8'h07, 8'h5e,
    8'h6a, 8'h72, 8'h32, 8'h24, 8'h16, 8'h08, 8'h09, 8'h5f,
    8'h6b, 8'h33, 8'h25, 8'h17, 8'h18, 8'h0b, 8'h0a, 8'h60,
    8'h6c, 8'h34, 8'h35, 8'h26, 8'h27, 8'h19, 8'h0c, 8'h61,
    8'h6d, 8'h73, 8'h28, 8'h74, 8'h1a, 8'h0d, 8'h62, 8'h6e,
    8'h3a, 8'h36, 8'h1c, 8'h1b, 8'h75, 8'h2b, 8'h63, 8'h76,
    8'h55, 8'h56, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h0e, 8'h7b,
    8'h7c, 8'h4f, 8'h7d, 8'h4b, 8'h47, 8'h7e, 8'h7f, 8'h6f,
    8'h52, 8'h53, 8'h50, 8'h4c, 8'h4d, 8'h48, 8'h01, 8'h45,
    8'h57, 8'h4e, 8'h51, 8'h4a, 8'h37, 8'h49, 8'h46, 8'h54
  };

  function automatic logic [7:0] to_set1(input logic [7:0] b);
    logic [7:0] v;
    if (!b[7]) begin
      v = SET1_LO[b[6:0]];
    end else begin
      case (b)
        8'h83:   v = 8'h41;
        8'h84:   v = 8'h54;
        8'hF0:   v = 8'h00;
        default: v = b;
      endcase
    end
    return v;
  endfunction

  // printable keysyms without the upper-case letters; bit 8 = needs shift
  function automatic logic [8:0] print_base(input logic [6:0] idx);
    logic [8:0] e;
    case (idx)
      7'h61: e = 9'h01c;  7'h62: e = 9'h032;  7'h63: e = 9'h021;  7'h64: e = 9'h023;
      7'h65: e = 9'h024;  7'h66: e = 9'h02b;  7'h67: e = 9'h034;  7'h68: e = 9'h033;
      7'h69: e = 9'h043;  7'h6a: e = 9'h03b;  7'h6b: e = 9'h042;  7'h6c: e = 9'h04b;
      7'h6d: e = 9'h03a;  7'h6e: e = 9'h031;  7'h6f: e = 9'h044;  7'h70: e = 9'h04d;
      7'h71: e = 9'h015;  7'h72: e = 9'h02d;  7'h73: e = 9'h01b;  7'h74: e = 9'h02c;
      7'h75: e = 9'h03c;  7'h76: e = 9'h02a;  7'h77: e = 9'h01d;  7'h78: e = 9'h022;
      7'h79: e = 9'h035;  7'h7a: e = 9'h01a;
      7'h60: e = 9'h00e;  7'h7e: e = 9'h10e;  7'h31: e = 9'h016;  7'h21: e = 9'h116;
      7'h32: e = 9'h01e;  7'h40: e = 9'h11e;  7'h33: e = 9'h026;  7'h23: e = 9'h126;
      7'h34: e = 9'h025;  7'h24: e = 9'h125;  7'h35: e = 9'h02e;  7'h25: e = 9'h12e;
      7'h36: e = 9'h036;  7'h5e: e = 9'h136;  7'h37: e = 9'h03d;  7'h26: e = 9'h13d;
      7'h38: e = 9'h03e;  7'h2a: e = 9'h13e;  7'h39: e = 9'h046;  7'h28: e = 9'h146;
      7'h30: e = 9'h045;  7'h29: e = 9'h145;  7'h2d: e = 9'h04e;  7'h5f: e = 9'h14e;
      7'h3d: e = 9'h055;  7'h2b: e = 9'h155;  7'h5b: e = 9'h054;  7'h7b: e = 9'h154;
      7'h5d: e = 9'h05b;  7'h7d: e = 9'h15b;  7'h5c: e = 9'h05d;  7'h7c: e = 9'h15d;
      7'h3b: e = 9'h04c;  7'h3a: e = 9'h14c;  7'h27: e = 9'h052;  7'h22: e = 9'h152;
      7'h2c: e = 9'h041;  7'h3c: e = 9'h141;  7'h2e: e = 9'h049;  7'h3e: e = 9'h149;
      7'h2f: e = 9'h04a;  7'h3f: e = 9'h14a;  7'h20: e = 9'h029;
      default: e = 9'h000;
    endcase
    return e;
  endfunction

  function automatic logic [8:0] print_map(input logic [6:0] idx);
    logic [8:0] e;
    if (idx inside {[7'h41:7'h5a]}) begin
      e = print_base(idx | 7'h20) | 9'h100;
    end else begin
      e = print_base(idx);
    end
    return e;
  endfunction

  // 0xFFxx keysyms; bit 8 = extended (E0 prefix)
  function automatic logic [8:0] special_map(input logic [7:0] idx);
    logic [8:0] e;
    case (idx)
      8'h08: e = 9'h066;  8'h09: e = 9'h00d;  8'h0d: e = 9'h05a;  8'h1b: e = 9'h076;
      8'h63: e = 9'h170;  8'hff: e = 9'h171;  8'h50: e = 9'h16c;  8'h57: e = 9'h169;
      8'h55: e = 9'h175;  8'h56: e = 9'h17a;  8'h51: e = 9'h174;  8'h52: e = 9'h175;
      8'h53: e = 9'h16b;  8'h54: e = 9'h172;  8'he1: e = 9'h012;  8'he2: e = 9'h059;
      8'he3: e = 9'h014;  8'he4: e = 9'h114;  8'he9: e = 9'h011;  8'hea: e = 9'h111;
      default: e = 9'h000;
    endcase
    return e;
  endfunction

endpackage

>>> hw/rtl/ksi_front.sv
module ksi_front
  import ksi_pkg::*;
(
  input  logic        opcode,
  input  logic [31:0] keysym,
  input  logic        key_down,
  output cmd_t        cmd
);

  logic [7:0] idx;
  logic [8:0] pe;
  logic [8:0] se;
  logic       is_print;
  logic       is_special;

  assign idx        = keysym[7:0];
  assign pe         = print_map(idx[6:0]);
  assign se         = special_map(idx);
  assign is_print   = (keysym[31:8] == '0);
  assign is_special = (keysym[31:8] == SPECIAL_PAGE);

  always_comb begin
    cmd         = '0;
    cmd.is_read = (opcode == OP_READ);
    if (opcode == OP_KEY) begin
      if (is_print) begin
        if (idx < PRINT_LIMIT && pe[7:0] != 8'h00) begin
          if (key_down) begin
            if (pe[8]) begin
              cmd.bytes[0] = SHIFT_CODE;
              cmd.bytes[1] = pe[7:0];
              cmd.nbytes   = 3'd2;
            end else begin
              cmd.bytes[0] = pe[7:0];
              cmd.nbytes   = 3'd1;
            end
          end else begin
            cmd.bytes[0] = BREAK_PREFIX;
            cmd.bytes[1] = pe[7:0];
            cmd.bytes[2] = BREAK_PREFIX;
            cmd.bytes[3] = SHIFT_CODE;
            cmd.nbytes   = pe[8] ? 3'd4 : 3'd2;
          end
        end
      end else if (is_special && se[7:0] != 8'h00) begin
        case ({se[8], key_down})
          2'b11: begin
            cmd.bytes[0] = EXT_PREFIX;
            cmd.bytes[1] = se[7:0];
            cmd.nbytes   = 3'd2;
          end
          2'b10: begin
            cmd.bytes[0] = EXT_PREFIX;
            cmd.bytes[1] = BREAK_PREFIX;
            cmd.bytes[2] = se[7:0];
            cmd.nbytes   = 3'd3;
          end
          2'b01: begin
            cmd.bytes[0] = se[7:0];
            cmd.nbytes   = 3'd1;
          end
          default: begin
            cmd.bytes[0] = BREAK_PREFIX;
            cmd.bytes[1] = se[7:0];
            cmd.nbytes   = 3'd2;
          end
        endcase
      end
    end
  end

endmodule

>>> hw/rtl/ksi_cmdq.sv
`include "assert_macros.svh"

module ksi_cmdq
  import ksi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t       slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `KSI_ASSERT(a_cmdq_no_overflow, clk, rst_n, !(push && full && !pop), "cmd queue overflow")

endmodule

>>> hw/rtl/ksi_back.sv
`include "assert_macros.svh"

module ksi_back
  import ksi_pkg::*;
#(
  parameter int FIFO_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       xlate,
  input  logic       q_valid,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  output logic [7:0] out_scancode,
  output logic       out_scancode_valid,
  output logic       out_data_pending,
  output logic       out_dropped
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_EMIT, S_RDWAIT} state_t;

  state_t           state_r;
  cmd_t             cmd_r;
  logic [1:0]       idx_r;
  logic             lost_r;
  logic             prefix_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] wr_ptr_r;
  logic [7:0]       fifo_mem [FIFO_DEPTH];
  logic [7:0]       rdata_r;

  logic             out_valid_r;
  logic [7:0]       out_scancode_r;
  logic             out_scancode_valid_r;
  logic             out_data_pending_r;
  logic             out_dropped_r;

  logic [7:0]       cur_byte;
  logic [7:0]       xbyte;
  logic             want;
  logic             prefix_nxt;
  logic             fifo_full;
  logic             do_push;
  logic             drop_now;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_adv;
  logic             last_byte;

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cur_byte   = cmd_r.bytes[idx_r];
  assign fifo_full  = (adv(wr_ptr_r) == rd_ptr_r);
  assign rd_ptr_adv = adv(rd_ptr_r);
  assign last_byte  = ({1'b0, idx_r} + 3'd1 == cmd_r.nbytes);
  assign q_pop      = (state_r == S_IDLE) && q_valid;

  // set-1 path: F0 is held back and marks the next byte as a break code
  always_comb begin
    xbyte      = cur_byte;
    want       = 1'b1;
    prefix_nxt = prefix_r;
    if (xlate) begin
      if (prefix_r) begin
        xbyte      = to_set1(cur_byte) | SET1_BREAK;
        prefix_nxt = 1'b0;
      end else if (cur_byte == BREAK_PREFIX) begin
        want       = 1'b0;
        prefix_nxt = 1'b1;
      end else begin
        xbyte = to_set1(cur_byte);
        want  = (xbyte != 8'h00);
      end
    end
  end

  assign do_push    = (state_r == S_EMIT) && want && !fifo_full;
  assign drop_now   = want && fifo_full;
  assign wr_ptr_nxt = do_push ? adv(wr_ptr_r) : wr_ptr_r;

  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo_mem[wr_ptr_r] <= xbyte;
    end
    rdata_r <= fifo_mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= 2'd0;
      lost_r      <= 1'b0;
      prefix_r    <= 1'b0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r  <= q_head;
            idx_r  <= 2'd0;
            lost_r <= 1'b0;
            if (q_head.is_read && rd_ptr_r != wr_ptr_r) begin
              state_r <= S_RDWAIT;
            end else if (!q_head.is_read && q_head.nbytes != 3'd0) begin
              state_r <= S_EMIT;
            end else begin
              // empty read or key that maps to nothing
              out_valid_r          <= 1'b1;
              out_scancode_r       <= 8'h00;
              out_scancode_valid_r <= 1'b0;
              out_data_pending_r   <= (rd_ptr_r != wr_ptr_r);
              out_dropped_r        <= 1'b0;
            end
          end
        end
        S_EMIT: begin
          wr_ptr_r <= wr_ptr_nxt;
          prefix_r <= prefix_nxt;
          idx_r    <= idx_r + 2'd1;
          lost_r   <= lost_r | drop_now;
          if (last_byte) begin
            state_r              <= S_IDLE;
            out_valid_r          <= 1'b1;
            out_scancode_r       <= 8'h00;
            out_scancode_valid_r <= 1'b0;
            out_data_pending_r   <= (rd_ptr_r != wr_ptr_nxt);
            out_dropped_r        <= lost_r | drop_now;
          end
        end
        S_RDWAIT: begin
          state_r              <= S_IDLE;
          rd_ptr_r             <= rd_ptr_adv;
          out_valid_r          <= 1'b1;
          out_scancode_r       <= rdata_r;
          out_scancode_valid_r <= 1'b1;
          out_data_pending_r   <= (rd_ptr_adv != wr_ptr_r);
          out_dropped_r        <= 1'b0;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_scancode       = out_scancode_r;
  assign out_scancode_valid = out_scancode_valid_r;
  assign out_data_pending   = out_data_pending_r;
  assign out_dropped        = out_dropped_r;

  `KSI_ASSERT(a_read_not_empty, clk, rst_n, (state_r == S_RDWAIT) |-> (rd_ptr_r != wr_ptr_r), "pop of empty byte fifo")
  `KSI_ASSERT(a_emit_in_range, clk, rst_n, (state_r == S_EMIT) |-> ({1'b0, idx_r} < cmd_r.nbytes), "byte index past sequence")
  `KSI_ASSERT_NEXT(a_read_result, clk, rst_n, (state_r == S_RDWAIT), (out_valid_r && out_scancode_valid_r), "read gave no byte")
  `KSI_ASSERT(a_valid_byte_strobed, clk, rst_n, out_scancode_valid_r |-> out_valid_r || $past(out_scancode_valid_r), "byte flag without strobe")

endmodule

>>> hw/rtl/keysym_to_ps2_scancode_injector_top.sv
// Keysym to PS/2 scan code injector.
// Input: pulse start with in_opcode/in_keysym/in_key_down while busy is low.
// A key event (opcode 0) is decoded into its set-2 make or break sequence
// (up to four bytes), optionally translated to set 1, and pushed into a byte
// fifo of FIFO_DEPTH entries (FIFO_DEPTH - 1 usable). A read (opcode 1) pops
// one byte if the fifo is not empty. Every command gives one result, shown
// for exactly one cycle with out_valid high; the receiver cannot stall, so
// results are never held. Decode sits in front of a two-entry command
// queue; busy is high when that queue is full. The back end takes a command
// only while idle and finishes it before the next: an empty read or an
// unmapped key is answered from the idle state, a read that pops waits on
// the registered read of the fifo memory, and a key event is emitted one
// byte per cycle, each written to the fifo unless held back or dropped.
// cfg_translate_to_set1 is written when cfg_valid is high (cfg_ready is
// always high); it resets to 1. Reset (rst_n low, synchronous) empties the
// fifo, the command queue and the pending set-1 break flag; no clearing pass.
module keysym_to_ps2_scancode_injector_top
  import ksi_pkg::*;
#(
  parameter int FIFO_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [31:0] in_keysym,
  input  logic        in_key_down,
  output logic        out_valid,
  output logic [7:0]  out_scancode,
  output logic        out_scancode_valid,
  output logic        out_data_pending,
  output logic        out_dropped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_translate_to_set1
);

  cmd_t dec_cmd;
  cmd_t q_head;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic xlate_r;

  assign busy      = q_full;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xlate_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      xlate_r <= cfg_translate_to_set1;
    end
  end

  ksi_front u_front (
    .opcode   (in_opcode),
    .keysym   (in_keysym),
    .key_down (in_key_down),
    .cmd      (dec_cmd)
  );

  ksi_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (start && !q_full),
    .push_cmd (dec_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  ksi_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .xlate              (xlate_r),
    .q_valid            (q_valid),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_scancode       (out_scancode),
    .out_scancode_valid (out_scancode_valid),
    .out_data_pending   (out_data_pending),
    .out_dropped        (out_dropped)
  );

endmodule

>>> tb/sv/keysym_to_ps2_scancode_injector_top_test.sv
module keysym_to_ps2_scancode_injector_top_test
  import ksi_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_SLOTS   = 127;   // 128-entry ring, one slot kept free
  localparam int CYCLE_LIMIT = 200_000;
  localparam int SETTLE_CYC  = 10;

  localparam string LETTERS    = "abcdefghijklmnopqrstuvwxyz";
  localparam string PLAIN_KEYS = "1234567890-=[]\\;',./";
  localparam string SHIFT_KEYS = "!@#$%^&*()_+{}|:\"<>?";

  localparam logic [7:0] LETTER_CODES [26] = '{
    8'h1c, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2b, 8'h34, 8'h33, 8'h43, 8'h3b,
    8'h42, 8'h4b, 8'h3a, 8'h31, 8'h44, 8'h4d, 8'h15, 8'h2d, 8'h1b, 8'h2c,
    8'h3c, 8'h2a, 8'h1d, 8'h22, 8'h35, 8'h1a
  };
  localparam logic [7:0] PLAIN_CODES [20] = '{
    8'h16, 8'h1e, 8'h26, 8'h25, 8'h2e, 8'h36, 8'h3d, 8'h3e, 8'h46, 8'h45,
    8'h4e, 8'h55, 8'h54, 8'h5b, 8'h5d, 8'h4c, 8'h52, 8'h41, 8'h49, 8'h4a
  };

  // 8042 set-2 to set-1 translation, codes 0x00..0x7F
  localparam logic [7:0] XLAT_LO [128] = '{
    8'hff, 8'h43, 8'h41, 8'h3f, 8'h3d, 8'h3b, 8'h3c, 8'h58, 8'h64, 8'h44, 8'h42, 8'h40,
    8'h3e, 8'h0f, 8'h29, 8'h59, 8'h65, 8'h38, 8'h2a, 8'h70, 8'h1d, 8'h10, 8'h02, 8'h5a,
    8'h66, 8'h71, 8'h2c, 8'h1f, 8'h1e, 8'h11, 8'h03, 8'h5b, 8'h67, 8'h2e, 8'h2d, 8'h20,
    8'h12, 8'h05, 8'h04, 8'h5c, 8'h68, 8'h39, 8'h2f, 8'h21, 8'h14, 8'h13, 8'h06, 8'h5d,
    8'h69, 8'h31, 8'h30, 8'h23, 8'h22, 8'h15, 8'h07, 8'h5e, 8'h6a, 8'h72, 8'h32, 8'h24,
    8'h16, 8'h08, 8'h09, 8'h5f, 8'h6b, 8'h33, 8'h25, 8'h17, 8'h18, 8'h0b, 8'h0a, 8'h60,
    8'h6c, 8'h34, 8'h35, 8'h26, 8'h27, 8'h19, 8'h0c, 8'h61, 8'h6d, 8'h73, 8'h28, 8'h74,
    8'h1a, 8'h0d, 8'h62, 8'h6e, 8'h3a, 8'h36, 8'h1c, 8'h1b, 8'h75, 8'h2b, 8'h63, 8'h76,
    8'h55, 8'h56, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h0e, 8'h7b, 8'h7c, 8'h4f, 8'h7d, 8'h4b,
    8'h47, 8'h7e, 8'h7f, 8'h6f, 8'h52, 8'h53, 8'h50, 8'h4c, 8'h4d, 8'h48, 8'h01, 8'h45,
    8'h57, 8'h4e, 8'h51, 8'h4a, 8'h37, 8'h49, 8'h46, 8'h54
  };

  typedef struct packed {
    logic        op;
    logic [31:0] keysym;
    logic        down;
  } key_cmd_t;

  typedef struct packed {
    logic [7:0] code;
    logic       popped;
    logic       pending;
    logic       lost;
  } scan_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_opcode = OP_KEY;
  logic [31:0] in_keysym = 32'h0;
  logic        in_key_down = 1'b0;
  logic        out_valid;
  logic [7:0]  out_scancode;
  logic        out_scancode_valid;
  logic        out_data_pending;
  logic        out_dropped;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_translate_to_set1 = 1'b1;

  keysym_to_ps2_scancode_injector_top #(
    .FIFO_DEPTH(128)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_keysym            (in_keysym),
    .in_key_down          (in_key_down),
    .out_valid            (out_valid),
    .out_scancode         (out_scancode),
    .out_scancode_valid   (out_scancode_valid),
    .out_data_pending     (out_data_pending),
    .out_dropped          (out_dropped),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_translate_to_set1(cfg_translate_to_set1)
  );

  always #6 clk = ~clk;

  // key maps of the scoreboard: bit 8 = shift (printable) or E0 prefix (special)
  logic [8:0] prt_map [0:127] = '{default: 9'h000};
  logic [8:0] spc_map [0:255] = '{default: 9'h000};

  // scoreboard copy of the block state
  logic [7:0] scan_buf [$];
  logic       set1_mode = 1'b1;
  logic       brk_pending = 1'b0;

  key_cmd_t     cmd_queue [$];
  scan_result_t scan_expect_q [$];

  int  gap_pct = 0;
  logic cmd_taken = 1'b0;
  int  fail_count = 0;
  int  cycle_count = 0;
  int  keys_taken = 0;
  int  reads_taken = 0;
  int  pops_seen = 0;
  int  drops_seen = 0;

  function automatic logic [7:0] set1_code(input logic [7:0] b);
    if (!b[7]) begin
      return XLAT_LO[b[6:0]];
    end else if (b == 8'h83) begin
      return 8'h41;
    end else if (b == 8'h84) begin
      return 8'h54;
    end else if (b == BREAK_PREFIX) begin
      return 8'h00;
    end
    return b;
  endfunction

  // returns 1 when the byte is lost to a full buffer
  function automatic logic buf_push(input logic [7:0] b);
    if (scan_buf.size() >= BUF_SLOTS) begin
      return 1'b1;
    end
    scan_buf.push_back(b);
    return 1'b0;
  endfunction

  function automatic logic send_byte(input logic [7:0] b);
    logic [7:0] v;
    if (!set1_mode) begin
      return buf_push(b);
    end
    if (brk_pending) begin
      brk_pending = 1'b0;
      v = set1_code(b) | SET1_BREAK;
    end else if (b == BREAK_PREFIX) begin
      brk_pending = 1'b1;   // swallowed, marks the next byte as a break
      return 1'b0;
    end else begin
      v = set1_code(b);
    end
    if (v == 8'h00) begin
      return 1'b0;
    end
    return buf_push(v);
  endfunction

  function automatic logic key_to_bytes(input logic [31:0] k, input logic down);
    logic [8:0] e;
    logic [7:0] idx;
    logic [7:0] seq [$];
    logic       lost;
    idx = k[7:0];
    lost = 1'b0;
    if (k[31:8] == 24'h0) begin
      if (idx >= 8'h7F) begin
        return 1'b0;
      end
      if (idx >= 8'h41 && idx <= 8'h5A) begin
        e = prt_map[idx[6:0] | 7'h20] | 9'h100;
      end else begin
        e = prt_map[idx[6:0]];
      end
      if (e[7:0] == 8'h00) begin
        return 1'b0;
      end
      if (down) begin
        if (e[8]) begin
          seq.push_back(SHIFT_CODE);
        end
        seq.push_back(e[7:0]);
      end else begin
        seq.push_back(BREAK_PREFIX);
        seq.push_back(e[7:0]);
        if (e[8]) begin
          seq.push_back(BREAK_PREFIX);
          seq.push_back(SHIFT_CODE);
        end
      end
    end else if (k[31:8] == SPECIAL_PAGE) begin
      e = spc_map[idx];
      if (e[7:0] == 8'h00) begin
        return 1'b0;
      end
      if (e[8]) begin
        seq.push_back(EXT_PREFIX);
      end
      if (!down) begin
        seq.push_back(BREAK_PREFIX);
      end
      seq.push_back(e[7:0]);
    end else begin
      return 1'b0;
    end
    foreach (seq[i]) begin
      if (send_byte(seq[i])) begin
        lost = 1'b1;
      end
    end
    return lost;
  endfunction

  function automatic scan_result_t predict_scan(input key_cmd_t c);
    scan_result_t r;
    r = '0;
    if (c.op == OP_READ) begin
      if (scan_buf.size() != 0) begin
        r.code = scan_buf.pop_front();
        r.popped = 1'b1;
      end
    end else begin
      r.lost = key_to_bytes(c.keysym, c.down);
    end
    r.pending = (scan_buf.size() != 0);
    return r;
  endfunction

  function automatic logic [31:0] random_keysym();
    int         pick;
    logic [7:0] idx;
    pick = $urandom_range(99);
    if (pick < 45) begin
      return 32'($urandom_range(8'h7E, 8'h20));
    end
    if (pick < 70) begin
      do begin
        idx = 8'($urandom_range(255));
      end while (spc_map[idx] == 9'h000);
      return {SPECIAL_PAGE, idx};
    end
    if (pick < 80) begin
      return 32'($urandom_range(255));
    end
    if (pick < 90) begin
      return {SPECIAL_PAGE, 8'($urandom_range(255))};
    end
    return $urandom;
  endfunction

  function automatic void add_key(input logic [31:0] k, input logic down);
    cmd_queue.push_back('{OP_KEY, k, down});
  endfunction

  function automatic void add_read();
    cmd_queue.push_back('{OP_READ, $urandom, 1'($urandom_range(1))});
  endfunction

  // typing bursts (press, mostly followed by release) then read bursts;
  // long bursts overrun the buffer, long read bursts run it dry
  function automatic void queue_random(input int count);
    int          made;
    int          n_keys;
    int          n_reads;
    logic [31:0] k;
    made = 0;
    while (made < count) begin
      n_keys = ($urandom_range(9) == 0) ? $urandom_range(70, 45) : $urandom_range(12, 1);
      n_reads = $urandom_range(3 * n_keys + 4);
      repeat (n_keys) begin
        k = random_keysym();
        add_key(k, 1'b1);
        made++;
        if ($urandom_range(99) < 70) begin
          add_key(k, 1'b0);
          made++;
        end else if ($urandom_range(99) < 15) begin
          add_read();
          made++;
        end
      end
      repeat (n_reads) begin
        add_read();
        made++;
      end
    end
  endfunction

  task automatic write_set1_mode(input logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_translate_to_set1 <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every command is taken and every result is back
  task automatic settle();
    while (cmd_queue.size() != 0 || start || scan_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  always @(negedge clk) begin : driver
    key_cmd_t nxt;
    logic     next_start;
    next_start = start;
    if (!start || cmd_taken) begin
      next_start = 1'b0;
      if (rst_n && cmd_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt = cmd_queue.pop_front();
        in_opcode <= nxt.op;
        in_keysym <= nxt.keysym;
        in_key_down <= nxt.down;
        next_start = 1'b1;
      end
    end
    start <= next_start;
  end

  always @(posedge clk) begin : monitor
    scan_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (scan_expect_q.size() == 0) begin
          $error("result with none expected: scancode %02h", out_scancode);
          fail_count++;
        end else begin
          want = scan_expect_q.pop_front();
          if (out_scancode !== want.code) begin
            $error("scancode: expected %02h, got %02h", want.code, out_scancode);
            fail_count++;
          end
          if (out_scancode_valid !== want.popped) begin
            $error("scancode_valid: expected %0b, got %0b", want.popped, out_scancode_valid);
            fail_count++;
          end
          if (out_data_pending !== want.pending) begin
            $error("data_pending: expected %0b, got %0b", want.pending, out_data_pending);
            fail_count++;
          end
          if (out_dropped !== want.lost) begin
            $error("dropped: expected %0b, got %0b", want.lost, out_dropped);
            fail_count++;
          end
          pops_seen += want.popped;
          drops_seen += want.lost;
        end
      end
      if (cfg_valid && cfg_ready) begin
        set1_mode = cfg_translate_to_set1;
      end
      if (start && !busy) begin
        scan_expect_q.push_back(predict_scan('{in_opcode, in_keysym, in_key_down}));
        if (in_opcode == OP_READ) begin
          reads_taken++;
        end else begin
          keys_taken++;
        end
      end
    end
    cmd_taken <= rst_n && start && !busy;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 26; i++) begin
      prt_map[7'(LETTERS[i])] = {1'b0, LETTER_CODES[i]};
    end
    for (int i = 0; i < 20; i++) begin
      prt_map[7'(PLAIN_KEYS[i])] = {1'b0, PLAIN_CODES[i]};
      prt_map[7'(SHIFT_KEYS[i])] = {1'b1, PLAIN_CODES[i]};
    end
    prt_map[7'h60] = 9'h00e;   // backquote
    prt_map[7'h7e] = 9'h10e;   // tilde
    prt_map[7'h20] = 9'h029;   // space
    spc_map[8'h08] = 9'h066;  spc_map[8'h09] = 9'h00d;  spc_map[8'h0d] = 9'h05a;
    spc_map[8'h1b] = 9'h076;  spc_map[8'h63] = 9'h170;  spc_map[8'hff] = 9'h171;
    spc_map[8'h50] = 9'h16c;  spc_map[8'h57] = 9'h169;  spc_map[8'h55] = 9'h175;
    spc_map[8'h56] = 9'h17a;  spc_map[8'h51] = 9'h174;  spc_map[8'h52] = 9'h175;
    spc_map[8'h53] = 9'h16b;  spc_map[8'h54] = 9'h172;  spc_map[8'he1] = 9'h012;
    spc_map[8'he2] = 9'h059;  spc_map[8'he3] = 9'h014;  spc_map[8'he4] = 9'h114;
    spc_map[8'he9] = 9'h011;  spc_map[8'hea] = 9'h111;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // set 1 (reset value): read of empty buffer, shifted and extended keys,
    // unmapped printable and special codes, keysyms outside both pages
    add_read();
    add_key(32'h61, 1'b1);
    add_key(32'h61, 1'b0);
    add_key(32'h41, 1'b1);
    add_key(32'h41, 1'b0);
    add_key(32'hFF63, 1'b1);
    add_key(32'hFFFF, 1'b0);
    add_key(32'h00, 1'b1);
    add_key(32'h7F, 1'b1);
    add_key(32'hFF, 1'b0);
    add_key(32'hFF00, 1'b1);
    add_key(32'hFFFF_FFFF, 1'b1);
    repeat (6) add_read();
    settle();

    // set 2: break prefixes pass through untranslated
    write_set1_mode(1'b0);
    add_key(32'h7E, 1'b0);
    add_key(32'hFFE4, 1'b1);
    add_key(32'hFF1B, 1'b0);
    add_key(32'h20, 1'b1);
    repeat (12) add_read();
    settle();

    gap_pct = 78;
    queue_random(180);
    settle();

    write_set1_mode(1'b1);
    gap_pct = 0;
    queue_random(230);
    settle();

    write_set1_mode(1'b0);
    gap_pct = 6;
    queue_random(140);
    settle();

    write_set1_mode(1'b1);
    gap_pct = 6;
    queue_random(160);
    settle();

    $display("Covered %0d key events and %0d reads in set 1 and set 2 modes,", keys_taken,
             reads_taken);
    $display("with %0d bytes popped and %0d events losing bytes to a full buffer.", pops_seen,
             drops_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ksi_pkg.sv
hw/rtl/ksi_front.sv
hw/rtl/ksi_cmdq.sv
hw/rtl/ksi_back.sv
hw/rtl/keysym_to_ps2_scancode_injector_top.sv
tb/sv/keysym_to_ps2_scancode_injector_top_test.sv
